### rtl/core/ssd3d_pkg.sv
// Shared constants, stage map and types for the 3D segment-to-segment distance pipeline.
// No dependencies; every other file in rtl/core imports this package.
package ssd3d_pkg;

    localparam int COORD_W         = 16;
    localparam int PARAM_FRAC_BITS = 16;
    localparam int DIST_FRAC_BITS  = 8;
    localparam int DIST_W          = 25;

    // arithmetic widths
    localparam int DIF_W    = COORD_W + 1;           // u, v, w components
    localparam int PRD_W    = 2 * DIF_W;             // component products
    localparam int DOT_W    = PRD_W + 2;             // a, b, c, d, e
    localparam int MD_W     = DOT_W + 1;             // -d, b - d
    localparam int BIG_W    = 2 * DOT_W;             // D and the numerators
    localparam int Q_W      = PARAM_FRAC_BITS + 1;   // sc, tc including the value one
    localparam int SPR_W    = Q_W + DIF_W + 1;       // sc * u, tc * v
    localparam int CMP_W    = SPR_W + 2;             // difference vector component
    localparam int MAG_W    = COORD_W + PARAM_FRAC_BITS + 2;
    localparam int SQR_W    = 2 * MAG_W;
    localparam int SUM_W    = SQR_W + 2;
    localparam int SQ_SHIFT = 2 * (PARAM_FRAC_BITS - DIST_FRAC_BITS);
    localparam int RAD_W    = SUM_W - SQ_SHIFT;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // stage map
    localparam int DIV_N    = PARAM_FRAC_BITS;
    localparam int ST_DIFF  = 0;
    localparam int ST_PROD  = 1;
    localparam int ST_DOT   = 2;
    localparam int ST_CROSS = 3;
    localparam int ST_NUM   = 4;
    localparam int ST_EDGE1 = 5;
    localparam int ST_EDGE2 = 6;
    localparam int ST_DPREP = 7;
    localparam int ST_DIV   = 8;
    localparam int ST_SCALE = ST_DIV + DIV_N;
    localparam int ST_COMP  = ST_SCALE + 1;
    localparam int ST_SQ    = ST_COMP + 1;
    localparam int ST_RAD   = ST_SQ + 1;
    localparam int ST_SQRT  = ST_RAD + 1;
    localparam int ST_OUT   = ST_SQRT + ROOT_W;
    localparam int N_STG    = ST_OUT + 1;

    typedef logic [2:0][DIF_W-1:0] t_vec3;

    typedef struct packed {
        t_vec3 u;
        t_vec3 v;
        t_vec3 w;
    } t_geo;

    typedef struct packed {
        logic signed [DOT_W-1:0] a;
        logic signed [DOT_W-1:0] b;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] d;
        logic signed [DOT_W-1:0] e;
    } t_dot;

    // restoring fraction divider state
    typedef struct packed {
        logic [BIG_W-1:0]           rem;
        logic [BIG_W-1:0]           den;
        logic [PARAM_FRAC_BITS-1:0] q;
        logic                       frc;
        logic                       frc_one;
    } t_div;

    // digit-by-digit square root state
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root;

endpackage

### rtl/core/ssd3d_req_if.sv
// Request channel of the segment distance block: two segments as twelve coordinates.
// Depends on ssd3d_pkg.
interface ssd3d_req_if;
    import ssd3d_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] a_start_x;
    logic signed [COORD_W-1:0] a_start_y;
    logic signed [COORD_W-1:0] a_start_z;
    logic signed [COORD_W-1:0] a_end_x;
    logic signed [COORD_W-1:0] a_end_y;
    logic signed [COORD_W-1:0] a_end_z;
    logic signed [COORD_W-1:0] b_start_x;
    logic signed [COORD_W-1:0] b_start_y;
    logic signed [COORD_W-1:0] b_start_z;
    logic signed [COORD_W-1:0] b_end_x;
    logic signed [COORD_W-1:0] b_end_y;
    logic signed [COORD_W-1:0] b_end_z;

    modport source (
        output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
        output b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        input  ready
    );

    modport sink (
        input  valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
        input  b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
        output ready
    );

endinterface

### rtl/core/ssd3d_rsp_if.sv
// Response channel of the segment distance block: one distance per request.
// Depends on ssd3d_pkg.
interface ssd3d_rsp_if;
    import ssd3d_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);

endinterface

### rtl/core/segment_to_segment_distance_3d_top.sv
// Shortest distance between two 3D segments, fully pipelined.
// Depends on ssd3d_pkg, ssd3d_req_if and ssd3d_rsp_if.
//
// Usage:
//   i_req carries one request: start and end points of segments A and B, twelve
//   signed 16-bit coordinates. It is taken on a clock edge with valid and ready high.
//   o_rsp returns the distance, unsigned with 8 fraction bits, floored and
//   saturated to 25 bits, one response per request and in request order.
//   The pipeline has 56 register stages:
//   8 stages for dot products and edge clamping, 16 stages for the two fraction
//   dividers (one quotient bit per stage), 4 stages for the difference vector and
//   its squared length, 27 stages for the square root (one root bit per stage)
//   and the output register.
//   Throughput is one request per cycle while o_rsp is not stalled. Every stage
//   carries a valid bit; a stage holds only while it is full and the stage after it
//   holds, so bubbles close up and i_req.ready stays high while o_rsp is stalled
//   until all 56 stages fill. No request is dropped or repeated under backpressure.
//   Synchronous active-low reset clears all valid bits; the block holds no other
//   state between requests.
module segment_to_segment_distance_3d_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ssd3d_req_if.sink    i_req,
    ssd3d_rsp_if.source  o_rsp
);
    import ssd3d_pkg::*;

    // ---------------------------------------------------------------- helpers
    function automatic t_div div_prep(input logic signed [BIG_W-1:0] num,
                                      input logic signed [BIG_W-1:0] den);
        t_div x;
        x.rem     = num;
        x.den     = den;
        x.q       = '0;
        x.frc     = 1'b0;
        x.frc_one = 1'b0;
        if (num == 0 || den == 0 || num < 0 || den < 0) begin
            x.frc = 1'b1;
        end else if (num >= den) begin
            x.frc     = 1'b1;
            x.frc_one = 1'b1;
        end
        return x;
    endfunction

    function automatic t_div div_step(input t_div x);
        t_div             y;
        logic [BIG_W-1:0] rem2;
        y    = x;
        rem2 = {x.rem[BIG_W-2:0], 1'b0};
        if (rem2 >= x.den) begin
            y.rem = rem2 - x.den;
            y.q   = {x.q[PARAM_FRAC_BITS-2:0], 1'b1};
        end else begin
            y.rem = rem2;
            y.q   = {x.q[PARAM_FRAC_BITS-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [Q_W-1:0] div_q(input t_div x);
        logic [Q_W-1:0] q;
        if (x.frc) begin
            q = x.frc_one ? (Q_W'(1) << PARAM_FRAC_BITS) : '0;
        end else begin
            q = {1'b0, x.q};
        end
        return q;
    endfunction

    function automatic t_root rt_step(input t_root x);
        t_root            y;
        logic [REM_W-1:0] trial;
        logic [REM_W-1:0] tv;
        trial = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
        tv    = {{(REM_W-ROOT_W-2){1'b0}}, x.root, 2'b01};
        y.rad = {x.rad[RAD_W-3:0], 2'b00};
        if (trial >= tv) begin
            y.rem  = trial - tv;
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end else begin
            y.rem  = trial;
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    // ------------------------------------------------------- valid / enables
    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] n_vld;
    logic [N_STG-1:0] stg_en;

    assign stg_en[N_STG-1] = !r_vld[N_STG-1] || o_rsp.ready;
    for (genvar k = 0; k < N_STG - 1; k++) begin : g_en
        assign stg_en[k] = !r_vld[k] || stg_en[k+1];
    end

    assign n_vld       = {r_vld[N_STG-2:0], i_req.valid};
    assign i_req.ready = stg_en[ST_DIFF];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (stg_en & n_vld) | (~stg_en & r_vld);
        end
    end

    // ------------------------------------------------ stage: difference vectors
    t_geo                    r_geo [0:ST_SCALE];
    t_geo                    n_geo;
    logic signed [DIF_W-1:0] a_s [3];
    logic signed [DIF_W-1:0] a_e [3];
    logic signed [DIF_W-1:0] b_s [3];
    logic signed [DIF_W-1:0] b_e [3];

    assign a_s[0] = DIF_W'(i_req.a_start_x);
    assign a_s[1] = DIF_W'(i_req.a_start_y);
    assign a_s[2] = DIF_W'(i_req.a_start_z);
    assign a_e[0] = DIF_W'(i_req.a_end_x);
    assign a_e[1] = DIF_W'(i_req.a_end_y);
    assign a_e[2] = DIF_W'(i_req.a_end_z);
    assign b_s[0] = DIF_W'(i_req.b_start_x);
    assign b_s[1] = DIF_W'(i_req.b_start_y);
    assign b_s[2] = DIF_W'(i_req.b_start_z);
    assign b_e[0] = DIF_W'(i_req.b_end_x);
    assign b_e[1] = DIF_W'(i_req.b_end_y);
    assign b_e[2] = DIF_W'(i_req.b_end_z);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_geo.u[i] = a_e[i] - a_s[i];
            n_geo.v[i] = b_e[i] - b_s[i];
            n_geo.w[i] = a_s[i] - b_s[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_DIFF]) begin
            r_geo[ST_DIFF] <= n_geo;
        end
    end

    // geometry rides along until the difference vector is formed
    for (genvar k = 1; k <= ST_SCALE; k++) begin : g_geo
        always_ff @(posedge i_clk) begin
            if (stg_en[k]) begin
                r_geo[k] <= r_geo[k-1];
            end
        end
    end

    // ------------------------------------------------ stage: component products
    logic signed [PRD_W-1:0] r_uu [3];
    logic signed [PRD_W-1:0] r_uv [3];
    logic signed [PRD_W-1:0] r_vv [3];
    logic signed [PRD_W-1:0] r_uw [3];
    logic signed [PRD_W-1:0] r_vw [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_PROD]) begin
            for (int i = 0; i < 3; i++) begin
                r_uu[i] <= $signed(r_geo[ST_DIFF].u[i]) * $signed(r_geo[ST_DIFF].u[i]);
                r_uv[i] <= $signed(r_geo[ST_DIFF].u[i]) * $signed(r_geo[ST_DIFF].v[i]);
                r_vv[i] <= $signed(r_geo[ST_DIFF].v[i]) * $signed(r_geo[ST_DIFF].v[i]);
                r_uw[i] <= $signed(r_geo[ST_DIFF].u[i]) * $signed(r_geo[ST_DIFF].w[i]);
                r_vw[i] <= $signed(r_geo[ST_DIFF].v[i]) * $signed(r_geo[ST_DIFF].w[i]);
            end
        end
    end

    // ------------------------------------------------ stage: dot products
    t_dot r_dot [ST_DOT:ST_NUM];
    t_dot n_dot;

    always_comb begin
        n_dot.a = DOT_W'(r_uu[0]) + DOT_W'(r_uu[1]) + DOT_W'(r_uu[2]);
        n_dot.b = DOT_W'(r_uv[0]) + DOT_W'(r_uv[1]) + DOT_W'(r_uv[2]);
        n_dot.c = DOT_W'(r_vv[0]) + DOT_W'(r_vv[1]) + DOT_W'(r_vv[2]);
        n_dot.d = DOT_W'(r_uw[0]) + DOT_W'(r_uw[1]) + DOT_W'(r_uw[2]);
        n_dot.e = DOT_W'(r_vw[0]) + DOT_W'(r_vw[1]) + DOT_W'(r_vw[2]);
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_DOT]) begin
            r_dot[ST_DOT] <= n_dot;
        end
        if (stg_en[ST_CROSS]) begin
            r_dot[ST_CROSS] <= r_dot[ST_DOT];
        end
        if (stg_en[ST_NUM]) begin
            r_dot[ST_NUM] <= r_dot[ST_CROSS];
        end
    end

    // ------------------------------------------------ stage: cross terms
    logic signed [BIG_W-1:0] r_ac, r_bb, r_be, r_cd, r_ae, r_bd;

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_CROSS]) begin
            r_ac <= r_dot[ST_DOT].a * r_dot[ST_DOT].c;
            r_bb <= r_dot[ST_DOT].b * r_dot[ST_DOT].b;
            r_be <= r_dot[ST_DOT].b * r_dot[ST_DOT].e;
            r_cd <= r_dot[ST_DOT].c * r_dot[ST_DOT].d;
            r_ae <= r_dot[ST_DOT].a * r_dot[ST_DOT].e;
            r_bd <= r_dot[ST_DOT].b * r_dot[ST_DOT].d;
        end
    end

    // ------------------------------------------------ stage: D and numerators
    logic signed [BIG_W-1:0] r_dd, r_sn0, r_tn0;

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_NUM]) begin
            r_dd  <= r_ac - r_bb;
            r_sn0 <= r_be - r_cd;
            r_tn0 <= r_ae - r_bd;
        end
    end

    // ------------------------------------------------ stage: clamp sc edges
    logic signed [BIG_W-1:0] n_sn1, n_sd1, n_tn1, n_td1;
    logic signed [BIG_W-1:0] r_sn1, r_sd1, r_tn1, r_td1;
    logic signed [MD_W-1:0]  n_md_lo, n_md_hi;
    logic signed [MD_W-1:0]  r_md_lo, r_md_hi;
    logic signed [DOT_W-1:0] r_a1;

    always_comb begin
        n_md_lo = -MD_W'(r_dot[ST_NUM].d);
        n_md_hi = MD_W'(r_dot[ST_NUM].b) - MD_W'(r_dot[ST_NUM].d);
        if (r_dd <= 0) begin
            // parallel or degenerate: sc pinned at zero
            n_sn1 = '0;
            n_sd1 = BIG_W'(1);
            n_tn1 = BIG_W'(r_dot[ST_NUM].e);
            n_td1 = BIG_W'(r_dot[ST_NUM].c);
        end else begin
            n_sn1 = r_sn0;
            n_sd1 = r_dd;
            n_tn1 = r_tn0;
            n_td1 = r_dd;
            if (r_sn0 < 0) begin
                n_sn1 = '0;
                n_tn1 = BIG_W'(r_dot[ST_NUM].e);
                n_td1 = BIG_W'(r_dot[ST_NUM].c);
            end else if (r_sn0 > r_dd) begin
                n_sn1 = r_dd;
                n_tn1 = BIG_W'(r_dot[ST_NUM].e) + BIG_W'(r_dot[ST_NUM].b);
                n_td1 = BIG_W'(r_dot[ST_NUM].c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_EDGE1]) begin
            r_sn1   <= n_sn1;
            r_sd1   <= n_sd1;
            r_tn1   <= n_tn1;
            r_td1   <= n_td1;
            r_md_lo <= n_md_lo;
            r_md_hi <= n_md_hi;
            r_a1    <= r_dot[ST_NUM].a;
        end
    end

    // ------------------------------------------------ stage: clamp tc edges
    logic signed [BIG_W-1:0] n_sn2, n_sd2, n_tn2;
    logic signed [BIG_W-1:0] r_sn2, r_sd2, r_tn2, r_td2;
    logic signed [MD_W-1:0]  md_sel;
    logic                    md_use;

    always_comb begin
        n_sn2  = r_sn1;
        n_sd2  = r_sd1;
        n_tn2  = r_tn1;
        md_use = 1'b0;
        md_sel = r_md_lo;
        if (r_tn1 < 0) begin
            n_tn2  = '0;
            md_use = 1'b1;
        end else if (r_tn1 > r_td1) begin
            n_tn2  = r_td1;
            md_use = 1'b1;
            md_sel = r_md_hi;
        end
        if (md_use) begin
            if (md_sel < 0) begin
                n_sn2 = '0;
            end else if (md_sel > MD_W'(r_a1)) begin
                n_sn2 = r_sd1;
            end else begin
                n_sn2 = BIG_W'(md_sel);
                n_sd2 = BIG_W'(r_a1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_EDGE2]) begin
            r_sn2 <= n_sn2;
            r_sd2 <= n_sd2;
            r_tn2 <= n_tn2;
            r_td2 <= r_td1;
        end
    end

    // ------------------------------------------------ fraction dividers
    t_div r_ds [0:DIV_N];
    t_div r_dt [0:DIV_N];

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_DPREP]) begin
            r_ds[0] <= div_prep(r_sn2, r_sd2);
            r_dt[0] <= div_prep(r_tn2, r_td2);
        end
    end

    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (stg_en[ST_DIV+k]) begin
                r_ds[k+1] <= div_step(r_ds[k]);
                r_dt[k+1] <= div_step(r_dt[k]);
            end
        end
    end

    // ------------------------------------------------ stage: sc*u, tc*v
    logic [Q_W-1:0]          sc, tc;
    logic signed [SPR_W-1:0] r_su [3];
    logic signed [SPR_W-1:0] r_tv [3];

    assign sc = div_q(r_ds[DIV_N]);
    assign tc = div_q(r_dt[DIV_N]);

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_SCALE]) begin
            for (int i = 0; i < 3; i++) begin
                r_su[i] <= $signed({1'b0, sc}) * $signed(r_geo[ST_SCALE-1].u[i]);
                r_tv[i] <= $signed({1'b0, tc}) * $signed(r_geo[ST_SCALE-1].v[i]);
            end
        end
    end

    // ------------------------------------------------ stage: difference vector
    logic signed [CMP_W-1:0] n_cmp [3];
    logic [MAG_W-1:0]        n_mag [3];
    logic [MAG_W-1:0]        r_mag [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_cmp[i] = (CMP_W'($signed(r_geo[ST_SCALE].w[i])) <<< PARAM_FRAC_BITS)
                     + CMP_W'(r_su[i]) - CMP_W'(r_tv[i]);
            n_mag[i] = (n_cmp[i] < 0) ? MAG_W'(-n_cmp[i]) : MAG_W'(n_cmp[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_COMP]) begin
            r_mag <= n_mag;
        end
    end

    // ------------------------------------------------ stage: squares
    logic [SQR_W-1:0] r_sqr [3];

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_SQ]) begin
            for (int i = 0; i < 3; i++) begin
                r_sqr[i] <= r_mag[i] * r_mag[i];
            end
        end
    end

    // ------------------------------------------------ stage: radicand
    logic [SUM_W-1:0] n_sum;
    t_root            r_rt [0:ROOT_W];

    assign n_sum = SUM_W'(r_sqr[0]) + SUM_W'(r_sqr[1]) + SUM_W'(r_sqr[2]);

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_RAD]) begin
            r_rt[0].rad  <= n_sum[SUM_W-1:SQ_SHIFT];
            r_rt[0].rem  <= '0;
            r_rt[0].root <= '0;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (stg_en[ST_SQRT+k]) begin
                r_rt[k+1] <= rt_step(r_rt[k]);
            end
        end
    end

    // ------------------------------------------------ output register
    logic [DIST_W-1:0] r_dist;

    always_ff @(posedge i_clk) begin
        if (stg_en[ST_OUT]) begin
            if (r_rt[ROOT_W].root > ROOT_W'(DIST_MAX)) begin
                r_dist <= DIST_MAX;
            end else begin
                r_dist <= r_rt[ROOT_W].root[DIST_W-1:0];
            end
        end
    end

    assign o_rsp.valid    = r_vld[ST_OUT];
    assign o_rsp.distance = r_dist;

endmodule
